>>> rtl/sbpr_pkg.sv
package sbpr_pkg;

    localparam int MAX_PADS     = 2;
    localparam int NUM_PADS     = 2;
    localparam int PINS_PER_PAD = 6;
    localparam int WORD_W       = 13;
    localparam int SKIP_W       = 2;

    localparam logic [SKIP_W-1:0] SKIP_NONE  = 2'd0;
    localparam logic [SKIP_W-1:0] SKIP_START = 2'd2;

    // pin positions
    localparam int PIN_D0 = 0;
    localparam int PIN_D1 = 1;
    localparam int PIN_D2 = 2;
    localparam int PIN_D3 = 3;
    localparam int PIN_TL = 4;
    localparam int PIN_TR = 5;

    // button word positions
    localparam int BTN_UP    = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_LEFT  = 2;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_A     = 4;
    localparam int BTN_B     = 5;
    localparam int BTN_C     = 6;
    localparam int BTN_X     = 7;
    localparam int BTN_Y     = 8;
    localparam int BTN_Z     = 9;
    localparam int BTN_START = 10;
    localparam int BTN_MODE  = 11;
    localparam int BTN_HOME  = 12;

    typedef logic [PINS_PER_PAD-1:0] pins_t;
    typedef logic [WORD_W-1:0]       word_t;

    typedef struct packed {
        pins_t pad0_pins;
        pins_t pad1_pins;
    } in_item_t;

    typedef struct packed {
        logic  select_level;
        word_t pad0_buttons;
        logic  pad0_changed;
        word_t pad1_buttons;
        logic  pad1_changed;
    } out_item_t;

    typedef struct packed {
        logic              connected;
        logic              six_mode;
        logic [SKIP_W-1:0] skip;
        word_t             word;
    } pad_state_t;

    // one poll of one pad, sel is the select level driven for this poll
    function automatic pad_state_t decode_pad(input pad_state_t cur, input pins_t pins,
                                              input logic sel);
        pad_state_t nxt;
        pins_t      pr;
        begin
            nxt = cur;
            pr  = ~pins;
            if (cur.skip != SKIP_NONE) begin
                if (cur.skip == SKIP_START) begin
                    nxt.word[BTN_HOME] = pr[PIN_D0];
                end
                nxt.skip = cur.skip - 1'b1;
            end else if (sel) begin
                if (cur.connected) begin
                    if (cur.six_mode) begin
                        nxt.word[BTN_Z]    = pr[PIN_D0];
                        nxt.word[BTN_Y]    = pr[PIN_D1];
                        nxt.word[BTN_X]    = pr[PIN_D2];
                        nxt.word[BTN_MODE] = pr[PIN_D3];
                        nxt.six_mode       = 1'b0;
                        nxt.skip           = SKIP_START;
                    end else begin
                        nxt.word[BTN_UP]    = pr[PIN_D0];
                        nxt.word[BTN_DOWN]  = pr[PIN_D1];
                        nxt.word[BTN_LEFT]  = pr[PIN_D2];
                        nxt.word[BTN_RIGHT] = pr[PIN_D3];
                        nxt.word[BTN_B]     = pr[PIN_TL];
                        nxt.word[BTN_C]     = pr[PIN_TR];
                    end
                end else begin
                    // two-fire fallback
                    nxt.word            = '0;
                    nxt.word[BTN_UP]    = pr[PIN_D0];
                    nxt.word[BTN_DOWN]  = pr[PIN_D1];
                    nxt.word[BTN_LEFT]  = pr[PIN_D2];
                    nxt.word[BTN_RIGHT] = pr[PIN_D3];
                    nxt.word[BTN_A]     = pr[PIN_TL];
                    nxt.word[BTN_B]     = pr[PIN_TR];
                end
            end else begin
                nxt.connected = pr[PIN_D2] & pr[PIN_D3];
                nxt.six_mode  = pr[PIN_D0] & pr[PIN_D1];
                if (nxt.connected && !nxt.six_mode) begin
                    nxt.word[BTN_A]     = pr[PIN_TL];
                    nxt.word[BTN_START] = pr[PIN_TR];
                end
            end
            return nxt;
        end
    endfunction

endpackage

>>> rtl/six_button_pad_reader.sv
// channel   ports                       payload      request
// input     s_valid s_ready s_data      in_item_t    one poll: pin levels of both pads
// result    m_valid m_ready m_data      out_item_t   select level, button words, changes
//
// one request accepted per cycle while the result is not stalled, its result appears in the next cycle
// pad state and the result register are updated at the accepting edge
// a stalled result holds the next request off only while it waits
// synchronous active-low reset: select high, pads unconnected, words clear
module six_button_pad_reader
    import sbpr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic       select_reg;
    logic       select_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    out_item_t  m_data_reg;
    out_item_t  m_data_next;
    logic       accept;

    pins_t      pins     [MAX_PADS];
    word_t      word_out [MAX_PADS];
    logic       chg_out  [MAX_PADS];

    assign s_ready     = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign select_next = accept ? ~select_reg : select_reg;
    assign pins[0]     = s_data.pad0_pins;
    assign pins[1]     = s_data.pad1_pins;

    for (genvar p = 0; p < MAX_PADS; p++) begin : g_pad
        if (p < NUM_PADS) begin : g_live
            pad_state_t pad_reg;
            pad_state_t pad_next;
            pad_state_t pad_poll;

            assign pad_poll    = decode_pad(pad_reg, pins[p], ~select_reg);
            assign pad_next    = accept ? pad_poll : pad_reg;
            assign word_out[p] = pad_poll.word;
            assign chg_out[p]  = pad_poll.word != pad_reg.word;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pad_reg <= '0;
                end else begin
                    pad_reg <= pad_next;
                end
            end
        end else begin : g_absent
            assign word_out[p] = '0;
            assign chg_out[p]  = 1'b0;
        end
    end

    always_comb begin
        m_data_next              = m_data_reg;
        m_valid_next             = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next              = 1'b1;
            m_data_next.select_level  = ~select_reg;
            m_data_next.pad0_buttons  = word_out[0];
            m_data_next.pad0_changed  = chg_out[0];
            m_data_next.pad1_buttons  = word_out[1];
            m_data_next.pad1_changed  = chg_out[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            select_reg  <= select_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/sbpr_checker.sv
module sbpr_checker
    import sbpr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic  last_sel_reg;
    logic  last_sel_next;
    word_t last_w0_reg;
    word_t last_w0_next;
    word_t last_w1_reg;
    word_t last_w1_next;
    logic  m_take;
    logic  s_take;

    assign m_take = m_valid && m_ready;
    assign s_take = s_valid && s_ready;

    always_comb begin
        last_sel_next = m_take ? m_data.select_level : last_sel_reg;
        last_w0_next  = m_take ? m_data.pad0_buttons : last_w0_reg;
        last_w1_next  = m_take ? m_data.pad1_buttons : last_w1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sel_reg <= 1'b1;
            last_w0_reg  <= '0;
            last_w1_reg  <= '0;
        end else begin
            last_sel_reg <= last_sel_next;
            last_w0_reg  <= last_w0_next;
            last_w1_reg  <= last_w1_next;
        end
    end

    // select alternates from one result to the next, low first
    a_select_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take |-> m_data.select_level != last_sel_reg)
        else $error("select level did not alternate");

    // change flags agree with the delivered words
    a_changed_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take |-> (m_data.pad0_changed == (m_data.pad0_buttons != last_w0_reg))
                && (m_data.pad1_changed == (m_data.pad1_buttons != last_w1_reg)))
        else $error("change flag disagrees with button word");

    // an accepted request always produces a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> m_valid)
        else $error("accepted request gave no result");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind six_button_pad_reader sbpr_checker u_sbpr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
